>>> src/abrf_pkg.sv
// types, codes and constants for the banked register file unit
package abrf_pkg;

    typedef enum logic [2:0] {
        OP_READ_REG     = 3'd0,
        OP_WRITE_REG    = 3'd1,
        OP_CHANGE_MODE  = 3'd2,
        OP_IRQ          = 3'd3,
        OP_CONDITION    = 3'd4,
        OP_WRITE_STATUS = 3'd5,
        OP_READ_STATUS  = 3'd6,
        OP_READ_SAVED   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } cond_t;

    // register bank selected by a mode
    typedef enum logic [2:0] {
        BANK_USR  = 3'd0,
        BANK_FIQ  = 3'd1,
        BANK_IRQ  = 3'd2,
        BANK_SVC  = 3'd3,
        BANK_ABT  = 3'd4,
        BANK_UND  = 3'd5,
        BANK_NONE = 3'd7
    } bank_t;

    localparam logic [4:0] MODE_USR = 5'd16;
    localparam logic [4:0] MODE_FIQ = 5'd17;
    localparam logic [4:0] MODE_IRQ = 5'd18;
    localparam logic [4:0] MODE_SVC = 5'd19;
    localparam logic [4:0] MODE_ABT = 5'd23;
    localparam logic [4:0] MODE_UND = 5'd27;
    localparam logic [4:0] MODE_SYS = 5'd31;

    localparam int BIT_N = 31;
    localparam int BIT_Z = 30;
    localparam int BIT_C = 29;
    localparam int BIT_V = 28;
    localparam int BIT_I = 7;
    localparam int BIT_T = 5;

    localparam logic [31:0] FLAG_MASK     = 32'hF000_00E0;
    localparam logic [31:0] STATUS_RESET  = 32'h0000_00D3;
    localparam logic [31:0] IRQ_VECTOR    = 32'h0000_0018;
    localparam logic [31:0] ARM_PC_OFFSET = 32'd4;

    localparam int NUM_VIS  = 16;
    localparam int NUM_FIQ  = 7;
    localparam int NUM_SHR  = 5;
    localparam int NUM_PAIR = 5;
    localparam int NUM_SPSR = 5;
    localparam int HIGH_BASE = 8;
    localparam int SP_IDX = 13;
    localparam int LR_IDX = 14;
    localparam int PC_IDX = 15;

    function automatic bank_t bank_of(input logic [4:0] mode);
        bank_t b;
        unique case (mode)
            MODE_USR, MODE_SYS: b = BANK_USR;
            MODE_FIQ:           b = BANK_FIQ;
            MODE_IRQ:           b = BANK_IRQ;
            MODE_SVC:           b = BANK_SVC;
            MODE_ABT:           b = BANK_ABT;
            MODE_UND:           b = BANK_UND;
            default:            b = BANK_NONE;
        endcase
        return b;
    endfunction

    // slot of the sp/lr pair kept for a non-fiq bank
    function automatic logic [2:0] pair_slot(input bank_t b);
        logic [2:0] s;
        unique case (b)
            BANK_IRQ: s = 3'd1;
            BANK_SVC: s = 3'd2;
            BANK_ABT: s = 3'd3;
            BANK_UND: s = 3'd4;
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

    // slot of the saved status for an exception bank
    function automatic logic [2:0] spsr_slot(input bank_t b);
        logic [2:0] s;
        unique case (b)
            BANK_FIQ: s = 3'd0;
            BANK_IRQ: s = 3'd1;
            BANK_SVC: s = 3'd2;
            BANK_ABT: s = 3'd3;
            BANK_UND: s = 3'd4;
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

>>> src/arm_banked_register_file_unit.sv
// banked register file, status register and condition check, one item per cycle
// result: done high one cycle, from the result register that follows the input register
// throughput: one item every cycle, busy is never raised; input register then one
//   pass of bank swap and flag logic into the state and result registers
// reset: r0-r15 and all banks clear, status 0xD3 (svc, I and F set), no result pending
// the receiver cannot stall: every result is shown for exactly one cycle
module arm_banked_register_file_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [3:0]  reg_index,
    input  logic [31:0] data,
    input  logic [4:0]  new_mode,
    input  logic [3:0]  cond,
    output logic        done,
    output logic [31:0] read_value,
    output logic        cond_true,
    output logic        irq_taken
);

    // input register
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [3:0]  idx_reg;
    logic [31:0] data_reg;
    logic [4:0]  mode_reg;
    logic [3:0]  cond_reg;

    // architectural state
    logic [31:0] vis_reg  [abrf_pkg::NUM_VIS];
    logic [31:0] fiq_reg  [abrf_pkg::NUM_FIQ];
    logic [31:0] shr_reg  [abrf_pkg::NUM_SHR];
    logic [31:0] sp_reg   [abrf_pkg::NUM_PAIR];
    logic [31:0] lr_reg   [abrf_pkg::NUM_PAIR];
    logic [31:0] spsr_reg [abrf_pkg::NUM_SPSR];
    logic [31:0] status_reg;

    logic [31:0] vis_next  [abrf_pkg::NUM_VIS];
    logic [31:0] fiq_next  [abrf_pkg::NUM_FIQ];
    logic [31:0] shr_next  [abrf_pkg::NUM_SHR];
    logic [31:0] sp_next   [abrf_pkg::NUM_PAIR];
    logic [31:0] lr_next   [abrf_pkg::NUM_PAIR];
    logic [31:0] spsr_next [abrf_pkg::NUM_SPSR];
    logic [31:0] status_next;

    // result register
    logic        done_reg;
    logic [31:0] value_reg;
    logic        ct_reg;
    logic        taken_reg;
    logic [31:0] value_next;
    logic        ct_next;
    logic        taken_next;

    // every item goes straight in, the work never backs up
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            idx_reg  <= reg_index;
            data_reg <= data;
            mode_reg <= new_mode;
            cond_reg <= cond;
        end
    end

    // single pass: decode, bank swap, irq entry, register and status access and flag check
    always_comb
    begin
        abrf_pkg::op_t   cur_op;
        abrf_pkg::bank_t src_bank;
        abrf_pkg::bank_t dst_bank;
        abrf_pkg::bank_t cur_bank;
        logic [4:0]      mode_sel;
        logic            do_change;
        logic            irq_go;
        logic            fn, fz, fc, fv;

        vis_next    = vis_reg;
        fiq_next    = fiq_reg;
        shr_next    = shr_reg;
        sp_next     = sp_reg;
        lr_next     = lr_reg;
        spsr_next   = spsr_reg;
        status_next = status_reg;
        value_next  = '0;
        ct_next     = 1'b0;
        taken_next  = 1'b0;

        cur_op   = abrf_pkg::op_t'(op_reg);
        cur_bank = abrf_pkg::bank_of(status_reg[4:0]);
        fn = status_reg[abrf_pkg::BIT_N];
        fz = status_reg[abrf_pkg::BIT_Z];
        fc = status_reg[abrf_pkg::BIT_C];
        fv = status_reg[abrf_pkg::BIT_V];

        irq_go    = in_valid_reg && (cur_op == abrf_pkg::OP_IRQ) &&
                    !status_reg[abrf_pkg::BIT_I];
        do_change = (in_valid_reg && (cur_op == abrf_pkg::OP_CHANGE_MODE)) || irq_go;
        mode_sel  = irq_go ? abrf_pkg::MODE_IRQ : mode_reg;
        src_bank  = cur_bank;
        dst_bank  = abrf_pkg::bank_of(mode_sel);

        if (irq_go)
        begin
            spsr_next[abrf_pkg::spsr_slot(abrf_pkg::BANK_IRQ)] = status_reg;
        end

        // mode change and bank swap
        if (do_change && (src_bank != abrf_pkg::BANK_NONE) &&
            (dst_bank != abrf_pkg::BANK_NONE))
        begin
            status_next[4:0] = mode_sel;
            if (src_bank != dst_bank)
            begin
                if (src_bank == abrf_pkg::BANK_FIQ)
                begin
                    for (int i = 0; i < abrf_pkg::NUM_FIQ; i++)
                    begin
                        fiq_next[i] = vis_reg[abrf_pkg::HIGH_BASE + i];
                    end
                    for (int i = 0; i < abrf_pkg::NUM_SHR; i++)
                    begin
                        vis_next[abrf_pkg::HIGH_BASE + i] = shr_reg[i];
                    end
                    vis_next[abrf_pkg::SP_IDX] = sp_reg[abrf_pkg::pair_slot(dst_bank)];
                    vis_next[abrf_pkg::LR_IDX] = lr_reg[abrf_pkg::pair_slot(dst_bank)];
                end
                else if (dst_bank == abrf_pkg::BANK_FIQ)
                begin
                    for (int i = 0; i < abrf_pkg::NUM_SHR; i++)
                    begin
                        shr_next[i] = vis_reg[abrf_pkg::HIGH_BASE + i];
                    end
                    sp_next[abrf_pkg::pair_slot(src_bank)] = vis_reg[abrf_pkg::SP_IDX];
                    lr_next[abrf_pkg::pair_slot(src_bank)] = vis_reg[abrf_pkg::LR_IDX];
                    for (int i = 0; i < abrf_pkg::NUM_FIQ; i++)
                    begin
                        vis_next[abrf_pkg::HIGH_BASE + i] = fiq_reg[i];
                    end
                end
                else
                begin
                    sp_next[abrf_pkg::pair_slot(src_bank)] = vis_reg[abrf_pkg::SP_IDX];
                    lr_next[abrf_pkg::pair_slot(src_bank)] = vis_reg[abrf_pkg::LR_IDX];
                    vis_next[abrf_pkg::SP_IDX] = sp_reg[abrf_pkg::pair_slot(dst_bank)];
                    vis_next[abrf_pkg::LR_IDX] = lr_reg[abrf_pkg::pair_slot(dst_bank)];
                end
            end
        end

        // irq entry finishing touches: mask, thumb exit, link and vector
        if (irq_go)
        begin
            taken_next = 1'b1;
            status_next[abrf_pkg::BIT_I] = 1'b1;
            if (status_reg[abrf_pkg::BIT_T])
            begin
                status_next[abrf_pkg::BIT_T] = 1'b0;
                vis_next[abrf_pkg::LR_IDX] = vis_reg[abrf_pkg::PC_IDX];
            end
            else
            begin
                vis_next[abrf_pkg::LR_IDX] = vis_reg[abrf_pkg::PC_IDX] - abrf_pkg::ARM_PC_OFFSET;
            end
            vis_next[abrf_pkg::PC_IDX] = abrf_pkg::IRQ_VECTOR;
        end

        if (in_valid_reg)
        begin
            unique case (cur_op)
                abrf_pkg::OP_READ_REG:
                begin
                    value_next = vis_reg[idx_reg];
                end
                abrf_pkg::OP_WRITE_REG:
                begin
                    vis_next[idx_reg] = data_reg;
                end
                abrf_pkg::OP_CONDITION:
                begin
                    unique case (abrf_pkg::cond_t'(cond_reg))
                        abrf_pkg::COND_EQ: ct_next = fz;
                        abrf_pkg::COND_NE: ct_next = !fz;
                        abrf_pkg::COND_CS: ct_next = fc;
                        abrf_pkg::COND_CC: ct_next = !fc;
                        abrf_pkg::COND_MI: ct_next = fn;
                        abrf_pkg::COND_PL: ct_next = !fn;
                        abrf_pkg::COND_VS: ct_next = fv;
                        abrf_pkg::COND_VC: ct_next = !fv;
                        abrf_pkg::COND_HI: ct_next = fc && !fz;
                        abrf_pkg::COND_LS: ct_next = !fc || fz;
                        abrf_pkg::COND_GE: ct_next = (fn == fv);
                        abrf_pkg::COND_LT: ct_next = (fn != fv);
                        abrf_pkg::COND_GT: ct_next = !fz && (fn == fv);
                        abrf_pkg::COND_LE: ct_next = fz || (fn != fv);
                        abrf_pkg::COND_AL: ct_next = 1'b1;
                        default:           ct_next = 1'b0;
                    endcase
                end
                abrf_pkg::OP_WRITE_STATUS:
                begin
                    status_next = (status_reg & ~abrf_pkg::FLAG_MASK) |
                                  (data_reg & abrf_pkg::FLAG_MASK);
                end
                abrf_pkg::OP_READ_STATUS:
                begin
                    value_next = status_reg;
                end
                abrf_pkg::OP_READ_SAVED:
                begin
                    // usr/sys and unknown modes have no saved status
                    if ((cur_bank != abrf_pkg::BANK_USR) && (cur_bank != abrf_pkg::BANK_NONE))
                    begin
                        value_next = spsr_reg[abrf_pkg::spsr_slot(cur_bank)];
                    end
                end
                default:
                begin
                    // mode change and irq handled above
                    value_next = '0;
                end
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < abrf_pkg::NUM_VIS; i++)
            begin
                vis_reg[i] <= '0;
            end
            for (int i = 0; i < abrf_pkg::NUM_FIQ; i++)
            begin
                fiq_reg[i] <= '0;
            end
            for (int i = 0; i < abrf_pkg::NUM_SHR; i++)
            begin
                shr_reg[i] <= '0;
            end
            for (int i = 0; i < abrf_pkg::NUM_PAIR; i++)
            begin
                sp_reg[i] <= '0;
                lr_reg[i] <= '0;
            end
            for (int i = 0; i < abrf_pkg::NUM_SPSR; i++)
            begin
                spsr_reg[i] <= '0;
            end
            status_reg <= abrf_pkg::STATUS_RESET;
            done_reg   <= 1'b0;
            value_reg  <= '0;
            ct_reg     <= 1'b0;
            taken_reg  <= 1'b0;
        end
        else
        begin
            vis_reg    <= vis_next;
            fiq_reg    <= fiq_next;
            shr_reg    <= shr_next;
            sp_reg     <= sp_next;
            lr_reg     <= lr_next;
            spsr_reg   <= spsr_next;
            status_reg <= status_next;
            done_reg   <= in_valid_reg;
            value_reg  <= value_next;
            ct_reg     <= ct_next;
            taken_reg  <= taken_next;
        end
    end

    assign done       = done_reg;
    assign read_value = value_reg;
    assign cond_true  = ct_reg;
    assign irq_taken  = taken_reg;

    // an item taken now shows its result after passing the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("result strobe missing two cycles after an accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result strobe without an item in flight");

    // irq entry leaves irq mode with interrupts masked and thumb cleared
    a_irq_state: assert property (@(posedge clk) disable iff (!rst_n)
        irq_taken |-> (done && status_reg[abrf_pkg::BIT_I] && !status_reg[abrf_pkg::BIT_T] &&
                       (status_reg[4:0] == abrf_pkg::MODE_IRQ)))
        else $error("irq taken but status not in irq mode with I set");

    // the mode bits only ever hold a known mode
    a_mode_known: assert property (@(posedge clk) disable iff (!rst_n)
        abrf_pkg::bank_of(status_reg[4:0]) != abrf_pkg::BANK_NONE)
        else $error("status holds an unknown mode");

    // only one kind of result per item
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (cond_true || irq_taken) |-> (done && (read_value == '0) && !(cond_true && irq_taken)))
        else $error("more than one result kind raised at once");

endmodule

>>> test/arm_banked_register_file_unit_tb.sv
// self-checking testbench for the banked register file unit
module arm_banked_register_file_unit_tb;

    // cycles with no item taken and no result seen before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // edges from taking an item to its result, plus margin for the final settle
    localparam int SETTLE_CYCLES = 4;

    // what one result should carry
    typedef struct packed {
        logic [31:0] value;
        logic        passed;
        logic        entered;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [3:0]  reg_index;
    logic [31:0] data;
    logic [4:0]  new_mode;
    logic [3:0]  cond;
    logic        done;
    logic [31:0] read_value;
    logic        cond_true;
    logic        irq_taken;

    // outcomes still owed by the block, oldest first
    outcome_t pending_outcomes[$];
    int       mismatch_count;
    int       quiet_cycles;
    int       idle_pct;

    // shadow of the architectural state
    logic [31:0] gpr [abrf_pkg::NUM_VIS];
    logic [31:0] fiq_bank [abrf_pkg::NUM_FIQ];
    logic [31:0] user_high [abrf_pkg::NUM_SHR];
    logic [31:0] saved_sp [abrf_pkg::NUM_PAIR];
    logic [31:0] saved_lr [abrf_pkg::NUM_PAIR];
    logic [31:0] cpsr;
    logic [31:0] spsr [abrf_pkg::NUM_SPSR];

    arm_banked_register_file_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .reg_index  (reg_index),
        .data       (data),
        .new_mode   (new_mode),
        .cond       (cond),
        .done       (done),
        .read_value (read_value),
        .cond_true  (cond_true),
        .irq_taken  (irq_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // shadow model of the register file
    // ---------------------------------------------------------------

    // bank that a mode code selects, none for an unlisted code
    function automatic abrf_pkg::bank_t mode_bank(input logic [4:0] m);
        case (m)
            abrf_pkg::MODE_USR, abrf_pkg::MODE_SYS: return abrf_pkg::BANK_USR;
            abrf_pkg::MODE_FIQ:                     return abrf_pkg::BANK_FIQ;
            abrf_pkg::MODE_IRQ:                     return abrf_pkg::BANK_IRQ;
            abrf_pkg::MODE_SVC:                     return abrf_pkg::BANK_SVC;
            abrf_pkg::MODE_ABT:                     return abrf_pkg::BANK_ABT;
            abrf_pkg::MODE_UND:                     return abrf_pkg::BANK_UND;
            default:                                return abrf_pkg::BANK_NONE;
        endcase
    endfunction

    // sp/lr shadow pair of a non-fiq bank, usr and sys share slot zero
    function automatic int shadow_slot(input abrf_pkg::bank_t b);
        return (b == abrf_pkg::BANK_USR) ? 0 : int'(b) - 1;
    endfunction

    // saved status entry of an exception bank, fiq first
    function automatic int saved_slot(input abrf_pkg::bank_t b);
        return int'(b) - 1;
    endfunction

    function automatic void apply_mode(input logic [4:0] m);
        abrf_pkg::bank_t from_bank;
        abrf_pkg::bank_t to_bank;
        int              s;
        int              i;
        from_bank = mode_bank(cpsr[4:0]);
        to_bank   = mode_bank(m);
        // unlisted mode codes leave everything alone
        if (from_bank == abrf_pkg::BANK_NONE || to_bank == abrf_pkg::BANK_NONE)
            return;
        cpsr[4:0] = m;
        // same bank, such as usr and sys: mode bits only
        if (from_bank == to_bank)
            return;
        if (from_bank == abrf_pkg::BANK_FIQ)
        begin
            // leaving fiq: park r8-r14, bring back the shared r8-r12 and the new sp/lr
            for (i = 0; i < abrf_pkg::NUM_FIQ; i++)
                fiq_bank[i] = gpr[abrf_pkg::HIGH_BASE + i];
            for (i = 0; i < abrf_pkg::NUM_SHR; i++)
                gpr[abrf_pkg::HIGH_BASE + i] = user_high[i];
            s = shadow_slot(to_bank);
            gpr[abrf_pkg::SP_IDX] = saved_sp[s];
            gpr[abrf_pkg::LR_IDX] = saved_lr[s];
        end
        else if (to_bank == abrf_pkg::BANK_FIQ)
        begin
            // entering fiq: park shared r8-r12 and the old sp/lr, fetch the fiq set
            for (i = 0; i < abrf_pkg::NUM_SHR; i++)
                user_high[i] = gpr[abrf_pkg::HIGH_BASE + i];
            s = shadow_slot(from_bank);
            saved_sp[s] = gpr[abrf_pkg::SP_IDX];
            saved_lr[s] = gpr[abrf_pkg::LR_IDX];
            for (i = 0; i < abrf_pkg::NUM_FIQ; i++)
                gpr[abrf_pkg::HIGH_BASE + i] = fiq_bank[i];
        end
        else
        begin
            // between non-fiq banks only sp and lr move
            s = shadow_slot(from_bank);
            saved_sp[s] = gpr[abrf_pkg::SP_IDX];
            saved_lr[s] = gpr[abrf_pkg::LR_IDX];
            s = shadow_slot(to_bank);
            gpr[abrf_pkg::SP_IDX] = saved_sp[s];
            gpr[abrf_pkg::LR_IDX] = saved_lr[s];
        end
    endfunction

    function automatic logic cond_holds(input abrf_pkg::cond_t c);
        logic n;
        logic z;
        logic cy;
        logic v;
        n  = cpsr[abrf_pkg::BIT_N];
        z  = cpsr[abrf_pkg::BIT_Z];
        cy = cpsr[abrf_pkg::BIT_C];
        v  = cpsr[abrf_pkg::BIT_V];
        case (c)
            abrf_pkg::COND_EQ: return z;
            abrf_pkg::COND_NE: return !z;
            abrf_pkg::COND_CS: return cy;
            abrf_pkg::COND_CC: return !cy;
            abrf_pkg::COND_MI: return n;
            abrf_pkg::COND_PL: return !n;
            abrf_pkg::COND_VS: return v;
            abrf_pkg::COND_VC: return !v;
            abrf_pkg::COND_HI: return cy && !z;
            abrf_pkg::COND_LS: return !cy || z;
            abrf_pkg::COND_GE: return n == v;
            abrf_pkg::COND_LT: return n != v;
            abrf_pkg::COND_GT: return !z && (n == v);
            abrf_pkg::COND_LE: return z || (n != v);
            abrf_pkg::COND_AL: return 1'b1;
            default:           return 1'b0;
        endcase
    endfunction

    function automatic logic enter_irq();
        logic [31:0] pc;
        // masked: nothing happens
        if (cpsr[abrf_pkg::BIT_I])
            return 1'b0;
        spsr[saved_slot(abrf_pkg::BANK_IRQ)] = cpsr;
        apply_mode(abrf_pkg::MODE_IRQ);
        cpsr[abrf_pkg::BIT_I] = 1'b1;
        pc = gpr[abrf_pkg::PC_IDX];
        // thumb state returns to pc itself, arm state to pc minus four
        if (cpsr[abrf_pkg::BIT_T])
        begin
            cpsr[abrf_pkg::BIT_T] = 1'b0;
            gpr[abrf_pkg::LR_IDX] = pc;
        end
        else
        begin
            gpr[abrf_pkg::LR_IDX] = pc - abrf_pkg::ARM_PC_OFFSET;
        end
        gpr[abrf_pkg::PC_IDX] = abrf_pkg::IRQ_VECTOR;
        return 1'b1;
    endfunction

    // apply one item to the shadow state and give the result it should cause
    function automatic outcome_t predict_outcome(input abrf_pkg::op_t o,
                                                 input logic [3:0] ri,
                                                 input logic [31:0] d, input logic [4:0] m,
                                                 input logic [3:0] c);
        outcome_t        res;
        abrf_pkg::bank_t b;
        res = '0;
        case (o)
            abrf_pkg::OP_READ_REG:     res.value = gpr[ri];
            abrf_pkg::OP_WRITE_REG:    gpr[ri] = d;
            abrf_pkg::OP_CHANGE_MODE:  apply_mode(m);
            abrf_pkg::OP_IRQ:          res.entered = enter_irq();
            abrf_pkg::OP_CONDITION:    res.passed = cond_holds(abrf_pkg::cond_t'(c));
            abrf_pkg::OP_WRITE_STATUS:
                cpsr = (cpsr & ~abrf_pkg::FLAG_MASK) | (d & abrf_pkg::FLAG_MASK);
            abrf_pkg::OP_READ_STATUS:  res.value = cpsr;
            default:
            begin
                // usr and sys have no saved status and read zero
                b = mode_bank(cpsr[4:0]);
                if (b != abrf_pkg::BANK_USR && b != abrf_pkg::BANK_NONE)
                    res.value = spsr[saved_slot(b)];
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking and item tracking, both sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result with no item outstanding: read_value %h", read_value);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (read_value !== want.value)
                    begin
                        $error("read_value: expected %h, got %h", want.value, read_value);
                        mismatch_count++;
                    end
                    if (cond_true !== want.passed)
                    begin
                        $error("cond_true: expected %b, got %b", want.passed, cond_true);
                        mismatch_count++;
                    end
                    if (irq_taken !== want.entered)
                    begin
                        $error("irq_taken: expected %b, got %b", want.entered, irq_taken);
                        mismatch_count++;
                    end
                end
            end
            // item taken at this edge: predict its result now
            if (start && !busy)
                pending_outcomes.push_back(predict_outcome(abrf_pkg::op_t'(op), reg_index,
                                                           data, new_mode, cond));
        end
    end

    // hang detector: counts edges with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // present one item, idling at random first, and return at the edge that takes it
    task automatic send_item(input abrf_pkg::op_t item_op, input logic [3:0] item_reg,
                             input logic [31:0] item_data, input logic [4:0] item_mode,
                             input logic [3:0] item_cond);
        while ($urandom_range(99) < idle_pct)
        begin
            // idle cycle with junk on the fields, which must be ignored
            start     <= 1'b0;
            op        <= 3'($urandom);
            reg_index <= 4'($urandom);
            data      <= $urandom;
            new_mode  <= 5'($urandom);
            cond      <= 4'($urandom);
            @(posedge clk);
        end
        start     <= 1'b1;
        op        <= item_op;
        reg_index <= item_reg;
        data      <= item_data;
        new_mode  <= item_mode;
        cond      <= item_cond;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_for_outcomes();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int            pick;
        abrf_pkg::op_t o;
        logic [31:0]   d;
        logic [4:0]    m;
        pick = $urandom_range(99);
        if (pick < 20)
            o = abrf_pkg::OP_READ_REG;
        else if (pick < 38)
            o = abrf_pkg::OP_WRITE_REG;
        else if (pick < 53)
            o = abrf_pkg::OP_CHANGE_MODE;
        else if (pick < 63)
            o = abrf_pkg::OP_IRQ;
        else if (pick < 78)
            o = abrf_pkg::OP_CONDITION;
        else if (pick < 88)
            o = abrf_pkg::OP_WRITE_STATUS;
        else if (pick < 94)
            o = abrf_pkg::OP_READ_STATUS;
        else
            o = abrf_pkg::OP_READ_SAVED;
        d = $urandom;
        // status writes mostly unmask interrupts so that irq entry keeps happening
        if (o == abrf_pkg::OP_WRITE_STATUS && $urandom_range(99) < 65)
            d[abrf_pkg::BIT_I] = 1'b0;
        // mostly listed modes, now and then any code at all
        case ($urandom_range(7))
            0:       m = abrf_pkg::MODE_USR;
            1:       m = abrf_pkg::MODE_FIQ;
            2:       m = abrf_pkg::MODE_IRQ;
            3:       m = abrf_pkg::MODE_SVC;
            4:       m = abrf_pkg::MODE_ABT;
            5:       m = abrf_pkg::MODE_UND;
            6:       m = abrf_pkg::MODE_SYS;
            default: m = 5'($urandom);
        endcase
        send_item(o, 4'($urandom), d, m, 4'($urandom));
    endtask

    // state straight after reset, and an interrupt refused while masked
    task automatic test_reset_state();
        send_item(abrf_pkg::OP_READ_STATUS, 4'($urandom), $urandom, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_READ_SAVED, 4'($urandom), $urandom, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_IRQ, 4'($urandom), $urandom, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_READ_REG, 4'd0, $urandom, 5'($urandom), 4'($urandom));
    endtask

    // all-ones and all-zero values, lowest and highest register numbers
    task automatic test_register_extremes();
        send_item(abrf_pkg::OP_WRITE_REG, 4'd0, 32'hFFFF_FFFF, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_WRITE_REG, 4'd15, 32'h0000_0000, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_WRITE_REG, 4'd14, 32'hFFFF_FFFF, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_READ_REG, 4'd0, $urandom, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_READ_REG, 4'd14, $urandom, 5'($urandom), 4'($urandom));
    endtask

    // flag writes keep the mode bits; never, always and equal conditions
    task automatic test_status_and_conditions();
        send_item(abrf_pkg::OP_WRITE_STATUS, 4'($urandom), 32'hFFFF_FFFF, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_READ_STATUS, 4'($urandom), $urandom, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_CONDITION, 4'($urandom), $urandom, 5'($urandom),
                  abrf_pkg::COND_NV);
        send_item(abrf_pkg::OP_CONDITION, 4'($urandom), $urandom, 5'($urandom),
                  abrf_pkg::COND_AL);
        send_item(abrf_pkg::OP_WRITE_STATUS, 4'($urandom), 32'h0000_0000, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_CONDITION, 4'($urandom), $urandom, 5'($urandom),
                  abrf_pkg::COND_EQ);
    endtask

    // unlisted code, usr to sys within one bank, fiq swap of the high registers
    task automatic test_mode_changes();
        send_item(abrf_pkg::OP_CHANGE_MODE, 4'($urandom), $urandom, 5'd0, 4'($urandom));
        send_item(abrf_pkg::OP_CHANGE_MODE, 4'($urandom), $urandom, abrf_pkg::MODE_USR,
                  4'($urandom));
        send_item(abrf_pkg::OP_CHANGE_MODE, 4'($urandom), $urandom, abrf_pkg::MODE_SYS,
                  4'($urandom));
        send_item(abrf_pkg::OP_READ_SAVED, 4'($urandom), $urandom, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_CHANGE_MODE, 4'($urandom), $urandom, abrf_pkg::MODE_FIQ,
                  4'($urandom));
        send_item(abrf_pkg::OP_WRITE_REG, 4'd8, 32'hA5A5_5A5A, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_CHANGE_MODE, 4'($urandom), $urandom, abrf_pkg::MODE_USR,
                  4'($urandom));
        send_item(abrf_pkg::OP_READ_REG, 4'd8, $urandom, 5'($urandom), 4'($urandom));
    endtask

    // interrupt taken from thumb state with I clear
    task automatic test_irq_entry();
        logic [31:0] thumb_unmasked;
        thumb_unmasked = '0;
        thumb_unmasked[abrf_pkg::BIT_T] = 1'b1;
        send_item(abrf_pkg::OP_WRITE_STATUS, 4'($urandom), thumb_unmasked, 5'($urandom),
                  4'($urandom));
        send_item(abrf_pkg::OP_IRQ, 4'($urandom), $urandom, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_READ_REG, 4'd14, $urandom, 5'($urandom), 4'($urandom));
        send_item(abrf_pkg::OP_READ_SAVED, 4'($urandom), $urandom, 5'($urandom),
                  4'($urandom));
    endtask

    // random mix with idle gaps, pausing now and then until the block is empty
    task automatic test_random_traffic(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            send_random_item();
            if (k % 128 == 127)
                wait_for_outcomes();
        end
    endtask

    // a long run of items on every cycle
    task automatic test_back_to_back(input int count);
        int k;
        idle_pct = 0;
        for (k = 0; k < count; k++)
            send_random_item();
        idle_pct = 38;
    endtask

    initial
    begin
        int i;
        mismatch_count = 0;
        idle_pct       = 38;
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = '0;
        reg_index = '0;
        data      = '0;
        new_mode  = '0;
        cond      = '0;
        // shadow state matches the block after reset
        for (i = 0; i < abrf_pkg::NUM_VIS; i++)
            gpr[i] = '0;
        for (i = 0; i < abrf_pkg::NUM_FIQ; i++)
            fiq_bank[i] = '0;
        for (i = 0; i < abrf_pkg::NUM_SHR; i++)
            user_high[i] = '0;
        for (i = 0; i < abrf_pkg::NUM_PAIR; i++)
        begin
            saved_sp[i] = '0;
            saved_lr[i] = '0;
        end
        for (i = 0; i < abrf_pkg::NUM_SPSR; i++)
            spsr[i] = '0;
        cpsr = abrf_pkg::STATUS_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_status_and_conditions();
        test_mode_changes();
        test_irq_entry();
        test_random_traffic(400);
        test_back_to_back(150);
        test_random_traffic(250);

        // drain, then give any stray result time to show
        wait_for_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", pending_outcomes.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> arm_banked_register_file_unit.f
src/abrf_pkg.sv
src/arm_banked_register_file_unit.sv
test/arm_banked_register_file_unit_tb.sv
